### rtl/core/bdc_pkg.sv
// ----------------------------------------------------------------------------
// bdc_pkg: shared types and constants for the particle domain bounds checker
// Word layouts, register indexes, exclusion codes and cell index limits.
// ----------------------------------------------------------------------------
package bdc_pkg;

  localparam int CELL_BITS    = 20;
  localparam int CFG_IDX_BITS = 3;
  localparam int CFG_DATA_BITS = 32;

  localparam logic [31:0] CELL_MAX      = 32'((64'd1 << CELL_BITS) - 64'd1);
  localparam logic [63:0] HUNDREDTH_Q32 = 64'd42949673;

  localparam logic [CFG_IDX_BITS-1:0] CFG_FLUID_MODE    = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_PERIODIC_AXES = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DOMAIN_SIZE_X = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DOMAIN_SIZE_Y = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DOMAIN_SIZE_Z = 3'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DENSITY_MIN   = 3'd5;
  localparam logic [CFG_IDX_BITS-1:0] CFG_DENSITY_MAX   = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] CFG_INV_CELL_SIZE = 3'd7;

  localparam logic [31:0] INV_CELL_RESET = 32'd65536;

  typedef enum logic [1:0] {
    EXCL_ACTIVE = 2'd0,
    EXCL_POS    = 2'd1,
    EXCL_DENS   = 2'd2,
    EXCL_SPEED  = 2'd3
  } excl_t;

  typedef struct packed {
    logic signed [31:0] rel_x;
    logic signed [31:0] rel_y;
    logic signed [31:0] rel_z;
    logic [31:0]        density;
    excl_t              excl_state;
    logic               is_floating;
    logic               last;
  } in_t;

  typedef struct packed {
    excl_t                new_excl_state;
    logic                 done_res;
    logic                 empty_res;
    logic [CELL_BITS-1:0] cell_min_x;
    logic [CELL_BITS-1:0] cell_min_y;
    logic [CELL_BITS-1:0] cell_min_z;
    logic [CELL_BITS-1:0] cell_max_x;
    logic [CELL_BITS-1:0] cell_max_y;
    logic [CELL_BITS-1:0] cell_max_z;
    logic [31:0]          density_out_count;
    logic [31:0]          speed_out_count;
    logic [31:0]          error_count;
  } out_t;

  typedef struct packed {
    logic        fluid_mode;
    logic [2:0]  periodic_axes;
    logic [30:0] domain_size_x;
    logic [30:0] domain_size_y;
    logic [30:0] domain_size_z;
    logic [31:0] density_min;
    logic [31:0] density_max;
  } cfg_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } vec3_t;

  typedef struct packed {
    excl_t       nexcl;
    logic        last;
    logic        empty;
    logic [31:0] dens_cnt;
    logic [31:0] spd_cnt;
    logic [31:0] err_cnt;
  } trk_t;

endpackage

### rtl/core/particle_domain_bounds_checker.sv
// ----------------------------------------------------------------------------
// particle_domain_bounds_checker: streaming domain check and cell bounds
// Checks each particle against the domain, updates exclusion state and
// counters, and reports the min/max cell range on the last word.
// ----------------------------------------------------------------------------
// One word is taken per clock and one result word leaves per clock while
// out_stall is low. The input register loads at the accept edge, then the
// rule and range update, the six 33x32 cell multiplies, and the output
// register with floor and saturation are registered in that order.
// Bubbles collapse, so input is taken while a result waits on a stalled
// output. The user must write configuration with cfg_we only while no word
// is in flight; the block itself does not enforce this.
module particle_domain_bounds_checker import bdc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  in_t                      in_word,
  output logic                     out_valid,
  input  logic                     out_stall,
  output out_t                     out_word,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_idx,
  input  logic [CFG_DATA_BITS-1:0] cfg_wdata
);

  cfg_t        cfg_r;
  logic [31:0] inv_r;

  in_t   s1_word_r;
  logic  s1_vld_r, s2_vld_r, s3_vld_r, out_vld_r;
  logic  ready1, ready2, ready3, adv_out, go1, go2, go3;
  trk_t  trk2, trk3_r;
  vec3_t lo2, hi2;
  out_t  out_word_r;
  logic [CELL_BITS-1:0] c_lo_x, c_lo_y, c_lo_z, c_hi_x, c_hi_y, c_hi_z;
  logic  keep;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{fluid_mode: 1'b1, periodic_axes: 3'd0, domain_size_x: 31'd0,
                 domain_size_y: 31'd0, domain_size_z: 31'd0, density_min: 32'd0,
                 density_max: 32'd0};
      inv_r <= INV_CELL_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_FLUID_MODE:    cfg_r.fluid_mode    <= cfg_wdata[0];
        CFG_PERIODIC_AXES: cfg_r.periodic_axes <= cfg_wdata[2:0];
        CFG_DOMAIN_SIZE_X: cfg_r.domain_size_x <= cfg_wdata[30:0];
        CFG_DOMAIN_SIZE_Y: cfg_r.domain_size_y <= cfg_wdata[30:0];
        CFG_DOMAIN_SIZE_Z: cfg_r.domain_size_z <= cfg_wdata[30:0];
        CFG_DENSITY_MIN:   cfg_r.density_min   <= cfg_wdata;
        CFG_DENSITY_MAX:   cfg_r.density_max   <= cfg_wdata;
        CFG_INV_CELL_SIZE: inv_r               <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    adv_out  = !out_vld_r || !out_stall;
    ready3   = !s3_vld_r || adv_out;
    ready2   = !s2_vld_r || ready3;
    ready1   = !s1_vld_r || ready2;
    go3      = s3_vld_r && adv_out;
    go2      = s2_vld_r && ready3;
    go1      = s1_vld_r && ready2;
    in_stall = !ready1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      s2_vld_r  <= 1'b0;
      s3_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (ready1)  s1_vld_r  <= in_valid;
      if (ready2)  s2_vld_r  <= s1_vld_r;
      if (ready3)  s3_vld_r  <= s2_vld_r;
      if (adv_out) out_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && ready1) s1_word_r <= in_word;
  end

  bdc_track u_track (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (go1),
    .cfg   (cfg_r),
    .w     (s1_word_r),
    .trk_r (trk2),
    .lo_r  (lo2),
    .hi_r  (hi2)
  );

  always_ff @(posedge clk) begin
    if (go2) trk3_r <= trk2;
  end

  bdc_cell u_lo_x (.clk(clk), .en(go2), .d(lo2.x), .inv(inv_r), .rnd(1'b0), .cell_idx(c_lo_x));
  bdc_cell u_lo_y (.clk(clk), .en(go2), .d(lo2.y), .inv(inv_r), .rnd(1'b0), .cell_idx(c_lo_y));
  bdc_cell u_lo_z (.clk(clk), .en(go2), .d(lo2.z), .inv(inv_r), .rnd(1'b0), .cell_idx(c_lo_z));
  bdc_cell u_hi_x (.clk(clk), .en(go2), .d(hi2.x), .inv(inv_r), .rnd(1'b1), .cell_idx(c_hi_x));
  bdc_cell u_hi_y (.clk(clk), .en(go2), .d(hi2.y), .inv(inv_r), .rnd(1'b1), .cell_idx(c_hi_y));
  bdc_cell u_hi_z (.clk(clk), .en(go2), .d(hi2.z), .inv(inv_r), .rnd(1'b1), .cell_idx(c_hi_z));

  assign keep = trk3_r.last && !trk3_r.empty;

  always_ff @(posedge clk) begin
    if (go3) begin
      out_word_r.new_excl_state    <= trk3_r.nexcl;
      out_word_r.done_res          <= trk3_r.last;
      out_word_r.empty_res         <= trk3_r.last && trk3_r.empty;
      out_word_r.cell_min_x        <= keep ? c_lo_x : '0;
      out_word_r.cell_min_y        <= keep ? c_lo_y : '0;
      out_word_r.cell_min_z        <= keep ? c_lo_z : '0;
      out_word_r.cell_max_x        <= keep ? c_hi_x : '0;
      out_word_r.cell_max_y        <= keep ? c_hi_y : '0;
      out_word_r.cell_max_z        <= keep ? c_hi_z : '0;
      out_word_r.density_out_count <= trk3_r.dens_cnt;
      out_word_r.speed_out_count   <= trk3_r.spd_cnt;
      out_word_r.error_count       <= trk3_r.err_cnt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_word  = out_word_r;

`ifndef SYNTH
  a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
    s1_vld_r && !ready2 |-> s2_vld_r && s3_vld_r && out_vld_r && out_stall)
    else $error("input stage held with a free slot downstream");
  a_cells_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_word_r.done_res |->
      (out_word_r.cell_min_x == '0) && (out_word_r.cell_max_x == '0) &&
      (out_word_r.empty_res == 1'b0))
    else $error("bounds fields set on a word that is not last");
  a_empty_cells: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_word_r.empty_res |->
      (out_word_r.cell_max_y == '0) && (out_word_r.cell_min_z == '0))
    else $error("cell fields set on an empty range");
`endif

endmodule

### rtl/core/bdc_track.sv
// ----------------------------------------------------------------------------
// bdc_track: exclusion rules and running range tracker
// Applies fluid or boundary rules to one word, updates the min/max and the
// counters, and registers the result with a snapshot of the range.
// ----------------------------------------------------------------------------
module bdc_track import bdc_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  cfg_t  cfg,
  input  in_t   w,
  output trk_t  trk_r,
  output vec3_t lo_r,
  output vec3_t hi_r
);

  vec3_t       mn_r, mx_r, mn_nxt, mx_nxt;
  logic        any_r, any_nxt;
  logic [31:0] dens_r, spd_r, err_r, dens_nxt, spd_nxt, err_nxt;
  logic [2:0]  ax_ok;
  logic        partin, dok, take, dinc, sinc, einc;
  excl_t       nexcl;

  always_comb begin
    ax_ok[0] = cfg.periodic_axes[0] || (!w.rel_x[31] && (w.rel_x[30:0] < cfg.domain_size_x));
    ax_ok[1] = cfg.periodic_axes[1] || (!w.rel_y[31] && (w.rel_y[30:0] < cfg.domain_size_y));
    ax_ok[2] = cfg.periodic_axes[2] || (!w.rel_z[31] && (w.rel_z[30:0] < cfg.domain_size_z));
    partin = &ax_ok;
    dok = (cfg.density_min <= w.density) && (w.density <= cfg.density_max);
    take  = 1'b0;
    dinc  = 1'b0;
    sinc  = 1'b0;
    einc  = 1'b0;
    nexcl = w.excl_state;
    if (cfg.fluid_mode) begin
      if (w.excl_state == EXCL_ACTIVE) begin
        if (partin && dok) begin
          take = 1'b1;
        end else begin
          nexcl = dok ? EXCL_POS : EXCL_DENS;
          dinc  = !dok;
          einc  = !partin && w.is_floating;
        end
      end else if (w.excl_state == EXCL_SPEED) begin
        sinc = 1'b1;
      end
    end else begin
      if (partin && (w.excl_state == EXCL_ACTIVE)) begin
        take = 1'b1;
      end else begin
        if (w.excl_state == EXCL_ACTIVE) nexcl = EXCL_POS;
        einc = 1'b1;
      end
    end

    mn_nxt.x = (take && (w.rel_x < mn_r.x)) ? w.rel_x : mn_r.x;
    mn_nxt.y = (take && (w.rel_y < mn_r.y)) ? w.rel_y : mn_r.y;
    mn_nxt.z = (take && (w.rel_z < mn_r.z)) ? w.rel_z : mn_r.z;
    mx_nxt.x = (take && (w.rel_x > mx_r.x)) ? w.rel_x : mx_r.x;
    mx_nxt.y = (take && (w.rel_y > mx_r.y)) ? w.rel_y : mx_r.y;
    mx_nxt.z = (take && (w.rel_z > mx_r.z)) ? w.rel_z : mx_r.z;
    any_nxt  = any_r || take;
    dens_nxt = dens_r + 32'(dinc);
    spd_nxt  = spd_r + 32'(sinc);
    err_nxt  = err_r + 32'(einc);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mn_r   <= '{x: 32'sh7FFFFFFF, y: 32'sh7FFFFFFF, z: 32'sh7FFFFFFF};
      mx_r   <= '{x: 32'sh80000000, y: 32'sh80000000, z: 32'sh80000000};
      any_r  <= 1'b0;
      dens_r <= '0;
      spd_r  <= '0;
      err_r  <= '0;
    end else if (en) begin
      dens_r <= dens_nxt;
      spd_r  <= spd_nxt;
      if (w.last) begin
        mn_r  <= '{x: 32'sh7FFFFFFF, y: 32'sh7FFFFFFF, z: 32'sh7FFFFFFF};
        mx_r  <= '{x: 32'sh80000000, y: 32'sh80000000, z: 32'sh80000000};
        any_r <= 1'b0;
        err_r <= '0;
      end else begin
        mn_r  <= mn_nxt;
        mx_r  <= mx_nxt;
        any_r <= any_nxt;
        err_r <= err_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      trk_r <= '{nexcl: nexcl, last: w.last, empty: !any_nxt,
                 dens_cnt: dens_nxt, spd_cnt: spd_nxt, err_cnt: err_nxt};
      lo_r  <= mn_nxt;
      hi_r  <= mx_nxt;
    end
  end

`ifndef SYNTH
  a_range_clear: assert property (@(posedge clk) disable iff (!rst_n)
    en && w.last |=> (err_r == 32'd0) && !any_r)
    else $error("range state not cleared after last word");
  a_dens_step: assert property (@(posedge clk) disable iff (!rst_n)
    en |=> ((dens_r - $past(dens_r)) <= 32'd1) && ((spd_r - $past(spd_r)) <= 32'd1))
    else $error("counter advanced by more than one");
  a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(dens_r) && $stable(spd_r) && $stable(err_r))
    else $error("counters moved without a word");
`endif

endmodule

### rtl/core/bdc_cell.sv
// ----------------------------------------------------------------------------
// bdc_cell: cell index of one coordinate
// Registers the Q32.32 product with the inverse cell size, then floors it,
// optionally after adding a hundredth of a cell, and saturates the index.
// ----------------------------------------------------------------------------
module bdc_cell import bdc_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [31:0]   d,
  input  logic [31:0]          inv,
  input  logic                 rnd,
  output logic [CELL_BITS-1:0] cell_idx
);

  logic signed [64:0] prod_full;
  logic signed [63:0] prod_r;
  logic [63:0]        sum;
  logic [31:0]        hi;

  assign prod_full = 65'(d) * 65'($signed({1'b0, inv}));

  always_ff @(posedge clk) begin
    if (en) prod_r <= prod_full[63:0];
  end

  always_comb begin
    sum = prod_r + (rnd ? HUNDREDTH_Q32 : 64'd0);
    hi  = sum[63:32];
    if (prod_r[63]) begin
      cell_idx = '0;
    end else if (hi > CELL_MAX) begin
      cell_idx = CELL_MAX[CELL_BITS-1:0];
    end else begin
      cell_idx = hi[CELL_BITS-1:0];
    end
  end

endmodule

### tb/sv/particle_domain_bounds_checker_tb.sv
// ----------------------------------------------------------------------------
// particle_domain_bounds_checker_tb: self-checking bench for the bounds checker
// Drives a directed table of particle words, then randomized particle ranges
// under changing register setups and sender and receiver stall patterns.
// Every result word is compared against an in-bench predictor, field by field.
// ----------------------------------------------------------------------------
module particle_domain_bounds_checker_tb;
  import bdc_pkg::*;

  localparam logic [31:0] ONE_Q16 = 32'h0001_0000;
  localparam logic [31:0] D100    = 32'h0064_0000;
  localparam logic [31:0] DENS_LO = 32'h0384_0000;
  localparam logic [31:0] DENS_HI = 32'h044C_0000;
  localparam logic [31:0] DENS_MID = 32'h03E8_0000;
  localparam int PHASES    = 12;
  localparam int PHASE_LEN = 88;

  typedef struct {
    logic                     is_cfg;
    logic [CFG_IDX_BITS-1:0]  idx;
    logic [CFG_DATA_BITS-1:0] data;
    in_t                      w;
    logic                     typed;
    excl_t                    t_excl;
    logic                     t_done;
    logic                     t_empty;
    logic [31:0]              t_err;
  } stim_row_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  in_t                      in_word = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  out_t                     out_word;
  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_idx = '0;
  logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;

  // predictor copy of the registers
  logic        mode_fluid;
  logic [2:0]  periodic;
  logic [30:0] dom_x, dom_y, dom_z;
  logic [31:0] dens_lo, dens_hi, inv_cell;

  // predictor copy of the range and counter state
  logic signed [31:0] lo_x, lo_y, lo_z, hi_x, hi_y, hi_z;
  logic               any_in;
  logic [31:0]        dens_out_tot, speed_out_tot, err_tot;

  out_t      pending_results[$];
  stim_row_t directed_rows[$];
  int        idle_pct = 0;
  int        stall_pct = 0;
  int        mismatches = 0;
  int        words_sent = 0;
  int        results_checked = 0;
  int        ranges_done = 0;
  int        setups = 0;

  particle_domain_bounds_checker u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  function automatic void clear_range();
    lo_x = 32'sh7FFF_FFFF; lo_y = 32'sh7FFF_FFFF; lo_z = 32'sh7FFF_FFFF;
    hi_x = 32'sh8000_0000; hi_y = 32'sh8000_0000; hi_z = 32'sh8000_0000;
    any_in = 1'b0;
    err_tot = '0;
  endfunction

  function automatic void take_point(in_t w);
    if (w.rel_x < lo_x) lo_x = w.rel_x;
    if (w.rel_y < lo_y) lo_y = w.rel_y;
    if (w.rel_z < lo_z) lo_z = w.rel_z;
    if (w.rel_x > hi_x) hi_x = w.rel_x;
    if (w.rel_y > hi_y) hi_y = w.rel_y;
    if (w.rel_z > hi_z) hi_z = w.rel_z;
    any_in = 1'b1;
  endfunction

  function automatic logic axis_in(logic signed [31:0] d, logic [30:0] size, logic wrap);
    return wrap || (!d[31] && d[30:0] < size);
  endfunction

  function automatic logic [CELL_BITS-1:0] cell_of(logic signed [31:0] d, logic [63:0] add);
    longint      prod;
    logic [63:0] c;
    prod = longint'(d) * longint'({32'd0, inv_cell});
    if (prod < 0) return '0;
    c = (64'(prod) + add) >> 32;
    if (c > 64'(CELL_MAX)) return CELL_MAX[CELL_BITS-1:0];
    return c[CELL_BITS-1:0];
  endfunction

  function automatic out_t predict_bounds(in_t w);
    out_t r;
    logic in_dom;
    logic dens_ok;
    r = '0;
    r.new_excl_state = w.excl_state;
    in_dom = axis_in(w.rel_x, dom_x, periodic[0]) && axis_in(w.rel_y, dom_y, periodic[1])
             && axis_in(w.rel_z, dom_z, periodic[2]);
    if (mode_fluid) begin
      if (w.excl_state == EXCL_ACTIVE) begin
        dens_ok = (w.density >= dens_lo) && (w.density <= dens_hi);
        if (in_dom && dens_ok) begin
          take_point(w);
        end else begin
          r.new_excl_state = dens_ok ? EXCL_POS : EXCL_DENS;
          if (!dens_ok) dens_out_tot++;
          if (!in_dom && w.is_floating) err_tot++;
        end
      end else if (w.excl_state == EXCL_SPEED) begin
        speed_out_tot++;
      end
    end else begin
      if (in_dom && w.excl_state == EXCL_ACTIVE) begin
        take_point(w);
      end else begin
        if (w.excl_state == EXCL_ACTIVE) r.new_excl_state = EXCL_POS;
        err_tot++;
      end
    end
    r.density_out_count = dens_out_tot;
    r.speed_out_count = speed_out_tot;
    r.error_count = err_tot;
    if (w.last) begin
      r.done_res = 1'b1;
      if (!any_in) begin
        r.empty_res = 1'b1;
      end else begin
        r.cell_min_x = cell_of(lo_x, 64'd0);
        r.cell_min_y = cell_of(lo_y, 64'd0);
        r.cell_min_z = cell_of(lo_z, 64'd0);
        r.cell_max_x = cell_of(hi_x, HUNDREDTH_Q32);
        r.cell_max_y = cell_of(hi_y, HUNDREDTH_Q32);
        r.cell_max_z = cell_of(hi_z, HUNDREDTH_Q32);
      end
      clear_range();
    end
    return r;
  endfunction

  function automatic stim_row_t mk_item(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                        logic [31:0] dens, excl_t e, logic flt, logic lst);
    stim_row_t r;
    r = '{default: '0, t_excl: EXCL_ACTIVE, w: '0};
    r.w.rel_x = x;
    r.w.rel_y = y;
    r.w.rel_z = z;
    r.w.density = dens;
    r.w.excl_state = e;
    r.w.is_floating = flt;
    r.w.last = lst;
    return r;
  endfunction

  function automatic stim_row_t typed_as(stim_row_t r, excl_t e, logic done, logic empty,
                                         logic [31:0] err);
    r.typed = 1'b1;
    r.t_excl = e;
    r.t_done = done;
    r.t_empty = empty;
    r.t_err = err;
    return r;
  endfunction

  function automatic stim_row_t cfg_row(logic [CFG_IDX_BITS-1:0] idx, logic [31:0] data);
    stim_row_t r;
    r = '{default: '0, t_excl: EXCL_ACTIVE, w: '0};
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.data = data;
    return r;
  endfunction

  function automatic logic [31:0] rand_coord(logic [30:0] size);
    int r;
    r = $urandom_range(99);
    if (r < 70 && size != 0) return $urandom_range({1'b0, size} - 32'd1);
    if (r < 80) return {1'b0, size};
    if (r < 85) return 32'hFFFF_FFFF;
    if (r < 88) return 32'h8000_0000;
    if (r < 91) return 32'h7FFF_FFFF;
    return $urandom();
  endfunction

  function automatic logic [31:0] rand_density();
    int r;
    r = $urandom_range(99);
    if (r < 70 && dens_lo <= dens_hi) return $urandom_range(dens_hi, dens_lo);
    if (r < 78) return dens_lo - 32'd1;
    if (r < 86) return dens_hi + 32'd1;
    if (r < 90) return 32'd0;
    if (r < 94) return 32'hFFFF_FFFF;
    return $urandom();
  endfunction

  function automatic stim_row_t rand_item(logic lst);
    excl_t e;
    e = ($urandom_range(99) < 80) ? EXCL_ACTIVE : excl_t'($urandom_range(3, 1));
    return mk_item(rand_coord(dom_x), rand_coord(dom_y), rand_coord(dom_z), rand_density(),
                   e, 1'($urandom_range(1)), lst);
  endfunction

  function automatic logic [31:0] rand_size();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 32'h7FFF_FFFF;
    if (r < 15) return 32'd0;
    if (r < 30) return $urandom();
    return $urandom_range(32'h00C8_0000, 32'd1);
  endfunction

  function automatic void cmp_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk) begin : check_results
    out_t want;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result word with no expectation pending");
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        results_checked++;
        cmp_field("new_excl_state", want.new_excl_state, out_word.new_excl_state);
        cmp_field("done_res", want.done_res, out_word.done_res);
        cmp_field("empty_res", want.empty_res, out_word.empty_res);
        cmp_field("cell_min_x", want.cell_min_x, out_word.cell_min_x);
        cmp_field("cell_min_y", want.cell_min_y, out_word.cell_min_y);
        cmp_field("cell_min_z", want.cell_min_z, out_word.cell_min_z);
        cmp_field("cell_max_x", want.cell_max_x, out_word.cell_max_x);
        cmp_field("cell_max_y", want.cell_max_y, out_word.cell_max_y);
        cmp_field("cell_max_z", want.cell_max_z, out_word.cell_max_z);
        cmp_field("density_out_count", want.density_out_count, out_word.density_out_count);
        cmp_field("speed_out_count", want.speed_out_count, out_word.speed_out_count);
        cmp_field("error_count", want.error_count, out_word.error_count);
      end
    end
  end

  task automatic send_word(stim_row_t r);
    out_t want;
    int   gap;
    in_valid <= 1'b1;
    in_word <= r.w;
    do @(posedge clk); while (in_stall !== 1'b0);
    want = predict_bounds(r.w);
    if (r.typed) begin
      want.new_excl_state = r.t_excl;
      want.done_res = r.t_done;
      want.empty_res = r.t_empty;
      want.error_count = r.t_err;
    end
    pending_results.push_back(want);
    words_sent++;
    if (r.w.last) ranges_done++;
    gap = 0;
    while (gap < 40 && $urandom_range(99) < idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // drop valid, drain every pending result, then cover the pipeline depth
  task automatic settle_block();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_reg(logic [CFG_IDX_BITS-1:0] idx, logic [31:0] val);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_FLUID_MODE:    mode_fluid = val[0];
      CFG_PERIODIC_AXES: periodic = val[2:0];
      CFG_DOMAIN_SIZE_X: dom_x = val[30:0];
      CFG_DOMAIN_SIZE_Y: dom_y = val[30:0];
      CFG_DOMAIN_SIZE_Z: dom_z = val[30:0];
      CFG_DENSITY_MIN:   dens_lo = val;
      CFG_DENSITY_MAX:   dens_hi = val;
      CFG_INV_CELL_SIZE: inv_cell = val;
      default: ;
    endcase
  endtask

  task automatic random_setup(int p);
    logic [31:0] vals [8];
    settle_block();
    if (p == 0) begin
      vals[CFG_FLUID_MODE] = 32'd1;
      vals[CFG_PERIODIC_AXES] = 32'd7;
      vals[CFG_DOMAIN_SIZE_X] = 32'h7FFF_FFFF;
      vals[CFG_DOMAIN_SIZE_Y] = 32'h7FFF_FFFF;
      vals[CFG_DOMAIN_SIZE_Z] = 32'h7FFF_FFFF;
      vals[CFG_DENSITY_MIN] = 32'd0;
      vals[CFG_DENSITY_MAX] = 32'hFFFF_FFFF;
      vals[CFG_INV_CELL_SIZE] = 32'hFFFF_FFFF;
    end else if (p == 1) begin
      vals[CFG_FLUID_MODE] = 32'd0;
      vals[CFG_PERIODIC_AXES] = 32'd0;
      vals[CFG_DOMAIN_SIZE_X] = 32'd1;
      vals[CFG_DOMAIN_SIZE_Y] = 32'd1;
      vals[CFG_DOMAIN_SIZE_Z] = 32'd1;
      vals[CFG_DENSITY_MIN] = 32'd0;
      vals[CFG_DENSITY_MAX] = 32'd0;
      vals[CFG_INV_CELL_SIZE] = 32'd0;
    end else begin
      vals[CFG_FLUID_MODE] = $urandom_range(1);
      vals[CFG_PERIODIC_AXES] = ($urandom_range(1) == 0) ? 32'd0 : $urandom();
      vals[CFG_DOMAIN_SIZE_X] = rand_size();
      vals[CFG_DOMAIN_SIZE_Y] = rand_size();
      vals[CFG_DOMAIN_SIZE_Z] = rand_size();
      vals[CFG_DENSITY_MIN] = $urandom_range(32'h0400_0000);
      vals[CFG_DENSITY_MAX] = ($urandom_range(9) == 0) ? $urandom() :
                              vals[CFG_DENSITY_MIN] + $urandom_range(32'h0200_0000);
      case ($urandom_range(3))
        0: vals[CFG_INV_CELL_SIZE] = ONE_Q16;
        1: vals[CFG_INV_CELL_SIZE] = $urandom_range(32'h0004_0000);
        2: vals[CFG_INV_CELL_SIZE] = $urandom();
        default: vals[CFG_INV_CELL_SIZE] = ONE_Q16 >> $urandom_range(8);
      endcase
    end
    for (int i = 0; i < 8; i++) set_reg(CFG_IDX_BITS'(i), vals[i]);
    setups++;
  endtask

  initial begin
    #1_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int n;
    int len;
    mode_fluid = 1'b1;
    periodic = '0;
    dom_x = '0; dom_y = '0; dom_z = '0;
    dens_lo = '0; dens_hi = '0;
    inv_cell = INV_CELL_RESET;
    dens_out_tot = '0;
    speed_out_tot = '0;
    clear_range();

    // reset registers first, then a small box with a density window
    directed_rows.push_back(typed_as(mk_item(0, 0, 0, 0, EXCL_ACTIVE, 1, 1),
                                     EXCL_POS, 1, 1, 1));
    directed_rows.push_back(typed_as(mk_item(0, 0, 0, 1, EXCL_ACTIVE, 0, 1),
                                     EXCL_DENS, 1, 1, 0));
    directed_rows.push_back(cfg_row(CFG_DOMAIN_SIZE_X, D100));
    directed_rows.push_back(cfg_row(CFG_DOMAIN_SIZE_Y, D100));
    directed_rows.push_back(cfg_row(CFG_DOMAIN_SIZE_Z, D100));
    directed_rows.push_back(cfg_row(CFG_DENSITY_MIN, DENS_LO));
    directed_rows.push_back(cfg_row(CFG_DENSITY_MAX, DENS_HI));
    directed_rows.push_back(typed_as(mk_item(32'h000A_0000, 32'h0014_0000, 32'h001E_0000,
                                     DENS_MID, EXCL_ACTIVE, 0, 0), EXCL_ACTIVE, 0, 0, 0));
    directed_rows.push_back(typed_as(mk_item(0, 0, 0, DENS_LO, EXCL_ACTIVE, 0, 0),
                                     EXCL_ACTIVE, 0, 0, 0));
    directed_rows.push_back(typed_as(mk_item(D100 - 1, D100 - 1, 32'h0004_FFFF, DENS_HI,
                                     EXCL_ACTIVE, 1, 0), EXCL_ACTIVE, 0, 0, 0));
    directed_rows.push_back(typed_as(mk_item(D100, 0, 0, DENS_MID, EXCL_ACTIVE, 1, 0),
                                     EXCL_POS, 0, 0, 1));
    directed_rows.push_back(typed_as(mk_item(0, 32'hFFFF_FFFF, 0, DENS_MID, EXCL_ACTIVE, 0, 0),
                                     EXCL_POS, 0, 0, 1));
    directed_rows.push_back(typed_as(mk_item(1, 1, 1, DENS_HI + 1, EXCL_ACTIVE, 0, 0),
                                     EXCL_DENS, 0, 0, 1));
    directed_rows.push_back(typed_as(mk_item(1, 1, 1, DENS_LO - 1, EXCL_ACTIVE, 1, 0),
                                     EXCL_DENS, 0, 0, 1));
    directed_rows.push_back(typed_as(mk_item(D100, D100, D100, 0, EXCL_POS, 1, 0),
                                     EXCL_POS, 0, 0, 1));
    directed_rows.push_back(typed_as(mk_item(0, 0, 0, 0, EXCL_DENS, 0, 0),
                                     EXCL_DENS, 0, 0, 1));
    directed_rows.push_back(typed_as(mk_item(0, 0, 0, 0, EXCL_SPEED, 0, 0),
                                     EXCL_SPEED, 0, 0, 1));
    directed_rows.push_back(typed_as(mk_item(32'h0032_0000, 32'h0032_0000, 32'h0032_0000,
                                     DENS_MID, EXCL_ACTIVE, 0, 1), EXCL_ACTIVE, 1, 0, 1));
    // all axes periodic, widest density window, largest reciprocal
    directed_rows.push_back(cfg_row(CFG_PERIODIC_AXES, 32'd7));
    directed_rows.push_back(cfg_row(CFG_INV_CELL_SIZE, 32'hFFFF_FFFF));
    directed_rows.push_back(cfg_row(CFG_DENSITY_MIN, 32'd0));
    directed_rows.push_back(cfg_row(CFG_DENSITY_MAX, 32'hFFFF_FFFF));
    directed_rows.push_back(typed_as(mk_item(32'h8000_0000, 32'h7FFF_FFFF, 0, 32'hFFFF_FFFF,
                                     EXCL_ACTIVE, 1, 0), EXCL_ACTIVE, 0, 0, 0));
    directed_rows.push_back(typed_as(mk_item(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 0,
                                     EXCL_ACTIVE, 0, 1), EXCL_ACTIVE, 1, 0, 0));
    // boundary rules
    directed_rows.push_back(cfg_row(CFG_FLUID_MODE, 32'd0));
    directed_rows.push_back(cfg_row(CFG_PERIODIC_AXES, 32'd0));
    directed_rows.push_back(cfg_row(CFG_INV_CELL_SIZE, ONE_Q16));
    directed_rows.push_back(typed_as(mk_item(32'h0001_0000, 32'h0002_0000, 32'h0003_0000,
                                     32'hFFFF_FFFF, EXCL_ACTIVE, 0, 0), EXCL_ACTIVE, 0, 0, 0));
    directed_rows.push_back(typed_as(mk_item(D100, 0, 0, 0, EXCL_ACTIVE, 1, 0),
                                     EXCL_POS, 0, 0, 1));
    directed_rows.push_back(typed_as(mk_item(0, 0, 0, 0, EXCL_DENS, 0, 0),
                                     EXCL_DENS, 0, 0, 2));
    directed_rows.push_back(typed_as(mk_item(0, 0, 0, 0, EXCL_SPEED, 1, 0),
                                     EXCL_SPEED, 0, 0, 3));
    directed_rows.push_back(typed_as(mk_item(0, 0, 0, 0, EXCL_POS, 0, 1),
                                     EXCL_POS, 1, 0, 4));
    directed_rows.push_back(typed_as(mk_item(D100, D100, D100, 0, EXCL_ACTIVE, 0, 1),
                                     EXCL_POS, 1, 1, 1));

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        settle_block();
        set_reg(directed_rows[i].idx, directed_rows[i].data);
      end else begin
        send_word(directed_rows[i]);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      random_setup(p);
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 82; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 82; end
        default: begin idle_pct = 14; stall_pct = 14; end
      endcase
      n = 0;
      while (n < PHASE_LEN) begin
        len = $urandom_range(14, 1);
        if (len > PHASE_LEN - n) len = PHASE_LEN - n;
        for (int k = 0; k < len; k++) send_word(rand_item(k == len - 1));
        n += len;
      end
    end

    idle_pct = 0;
    stall_pct = 0;
    settle_block();

    $display("Sent %0d particle words in %0d ranges across %0d random register setups.",
             words_sent, ranges_done, setups);
    $display("Checked %0d result words under mixed sender and receiver stalls.",
             results_checked);
    if (mismatches == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
